FILE: hw/rtl/ppfd_pkg.sv
// ----------------------------------------------------------------------------
// ppfd_pkg
// Shared types and constants for the pulse pair frame decoder.
// ----------------------------------------------------------------------------
package ppfd_pkg;

  localparam int IDX_W = 7;
  localparam int LEN_W = 16;
  localparam int CODE_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // pulses in a valid frame
  localparam logic [IDX_W-1:0] FRAME_PULSES = 7'd66;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_MULTIPLIER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MAX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_MIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_MAX = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_MIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_MAX = 3'd6;

  // register reset values
  localparam logic [7:0] MULTIPLIER_RST = 8'd32;
  localparam logic [LEN_W-1:0] SHORT_MIN_RST = 16'd380;
  localparam logic [LEN_W-1:0] SHORT_MAX_RST = 16'd530;
  localparam logic [LEN_W-1:0] LONG_MIN_RST = 16'd740;
  localparam logic [LEN_W-1:0] LONG_MAX_RST = 16'd1050;
  localparam logic [LEN_W-1:0] HEADER_MIN_RST = 16'd1900;
  localparam logic [LEN_W-1:0] HEADER_MAX_RST = 16'd2250;

  typedef struct packed {
    logic [7:0] pulse_units;
    logic       last_pulse;
  } pulse_t;

  typedef struct packed {
    logic              frame_ok;
    logic [CODE_W-1:0] code;
  } result_t;

endpackage

FILE: hw/rtl/pulse_pair_frame_decoder.sv
// ----------------------------------------------------------------------------
// pulse_pair_frame_decoder
// Checks a captured pulse-width frame pulse by pulse and builds the pair code.
// ----------------------------------------------------------------------------
// result path: a pulse passes the input register, then the result register
// throughput: one pulse per cycle while no final pulse stalls; the multiply, compares and code shift sit in one stage
// a final pulse stalls only while the result register is full and not taken
// reset: synchronous, clears capture state, restores register defaults, drops valids
module pulse_pair_frame_decoder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pulse_valid,
  output logic                                pulse_stall,
  input  ppfd_pkg::pulse_t                    pulse,
  output logic                                result_valid,
  input  logic                                result_stall,
  output ppfd_pkg::result_t                   result,
  input  logic                                cfg_we,
  input  logic [ppfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ppfd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  typedef enum logic [1:0] {
    KIND_BAD,
    KIND_SHORT,
    KIND_LONG
  } kind_t;

  // config registers
  logic [7:0]                     multiplier;
  logic [ppfd_pkg::LEN_W-1:0]     short_min;
  logic [ppfd_pkg::LEN_W-1:0]     short_max;
  logic [ppfd_pkg::LEN_W-1:0]     long_min;
  logic [ppfd_pkg::LEN_W-1:0]     long_max;
  logic [ppfd_pkg::LEN_W-1:0]     header_min;
  logic [ppfd_pkg::LEN_W-1:0]     header_max;

  // input register
  logic             s1_valid;
  ppfd_pkg::pulse_t s1_pulse;
  logic             s1_go;

  // capture state
  logic [ppfd_pkg::IDX_W-1:0]  pulse_index;
  logic [ppfd_pkg::CODE_W-1:0] code_shift;
  logic                        failed;
  logic                        pair_first_long;

  logic [ppfd_pkg::IDX_W-1:0]  pulse_index_next;
  logic [ppfd_pkg::CODE_W-1:0] code_shift_next;
  logic                        failed_next;
  logic                        pair_first_long_next;

  logic [ppfd_pkg::LEN_W-1:0]  len;
  logic [ppfd_pkg::IDX_W:0]    idx_inc;
  logic [ppfd_pkg::IDX_W:0]    pair_end;
  logic                        in_pairs;
  kind_t                       kind;
  logic                        ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      multiplier <= ppfd_pkg::MULTIPLIER_RST;
      short_min  <= ppfd_pkg::SHORT_MIN_RST;
      short_max  <= ppfd_pkg::SHORT_MAX_RST;
      long_min   <= ppfd_pkg::LONG_MIN_RST;
      long_max   <= ppfd_pkg::LONG_MAX_RST;
      header_min <= ppfd_pkg::HEADER_MIN_RST;
      header_max <= ppfd_pkg::HEADER_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ppfd_pkg::CFG_MULTIPLIER: multiplier <= cfg_data[7:0];
        ppfd_pkg::CFG_SHORT_MIN:  short_min  <= cfg_data;
        ppfd_pkg::CFG_SHORT_MAX:  short_max  <= cfg_data;
        ppfd_pkg::CFG_LONG_MIN:   long_min   <= cfg_data;
        ppfd_pkg::CFG_LONG_MAX:   long_max   <= cfg_data;
        ppfd_pkg::CFG_HEADER_MIN: header_min <= cfg_data;
        ppfd_pkg::CFG_HEADER_MAX: header_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // a non-final pulse only updates state, so it never waits on the result side
  assign s1_go       = !s1_pulse.last_pulse || !result_valid || !result_stall;
  assign pulse_stall = s1_valid && !s1_go;

  always_comb begin
    len = ppfd_pkg::LEN_W'(s1_pulse.pulse_units) * ppfd_pkg::LEN_W'(multiplier);

    if (len < short_min) begin
      kind = KIND_BAD;
    end else if (len <= short_max) begin
      kind = KIND_SHORT;
    end else if (len < long_min || len > long_max) begin
      kind = KIND_BAD;
    end else begin
      kind = KIND_LONG;
    end

    // pulse number within the capture, saturating
    idx_inc = {1'b0, pulse_index} + 1'b1;
    if (idx_inc[ppfd_pkg::IDX_W]) begin
      pulse_index_next = {ppfd_pkg::IDX_W{1'b1}};
    end else begin
      pulse_index_next = idx_inc[ppfd_pkg::IDX_W-1:0];
    end

    // second pulse of this pair must fall before the last pulse of the frame
    pair_end = pulse_index_next[0] ? ({1'b0, pulse_index_next} + 1'b1)
                                   : {1'b0, pulse_index_next};
    in_pairs = pair_end < {1'b0, ppfd_pkg::FRAME_PULSES};

    failed_next          = failed;
    code_shift_next      = code_shift;
    pair_first_long_next = pair_first_long;

    if (pulse_index_next == ppfd_pkg::IDX_W'(1)) begin
      if (len <= long_min || len >= long_max) begin
        failed_next = 1'b1;
      end
    end else if (pulse_index_next == ppfd_pkg::IDX_W'(2)) begin
      if (len <= header_min || len >= header_max) begin
        failed_next = 1'b1;
      end
    end else if (in_pairs) begin
      if (pulse_index_next[0]) begin
        if (kind == KIND_BAD) begin
          failed_next = 1'b1;
        end
        pair_first_long_next = (kind == KIND_LONG);
      end else begin
        if (kind != KIND_LONG) begin
          failed_next = 1'b1;
        end
        // add the bit, then shift
        code_shift_next = (code_shift + ppfd_pkg::CODE_W'(pair_first_long)) << 1;
        pair_first_long_next = 1'b0;
      end
    end

    ok = !failed_next && (pulse_index_next == ppfd_pkg::FRAME_PULSES);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      pulse_index     <= '0;
      code_shift      <= '0;
      failed          <= 1'b0;
      pair_first_long <= 1'b0;
      result_valid    <= 1'b0;
    end else begin
      if (!pulse_stall) begin
        s1_valid <= pulse_valid;
      end

      if (s1_valid && s1_go && s1_pulse.last_pulse) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      if (s1_valid && s1_go) begin
        if (s1_pulse.last_pulse) begin
          pulse_index     <= '0;
          code_shift      <= '0;
          failed          <= 1'b0;
          pair_first_long <= 1'b0;
        end else begin
          pulse_index     <= pulse_index_next;
          code_shift      <= code_shift_next;
          failed          <= failed_next;
          pair_first_long <= pair_first_long_next;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!pulse_stall && pulse_valid) begin
      s1_pulse <= pulse;
    end
    if (s1_valid && s1_go && s1_pulse.last_pulse) begin
      result.frame_ok <= ok;
      result.code     <= ok ? code_shift_next : '0;
    end
  end

endmodule

FILE: dv/pulse_pair_frame_decoder_tb.sv
// ----------------------------------------------------------------------------
// pulse_pair_frame_decoder_tb
// Drives captured pulse frames into the decoder under several register
// settings and idle patterns, predicts every frame verdict and pair code,
// and compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module pulse_pair_frame_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ppfd_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 4;
  localparam int INDEX_CEILING = 127;

  typedef enum logic [1:0] {PULSE_BAD, PULSE_SHORT, PULSE_LONG} pulse_kind_t;
  typedef enum logic [1:0] {
    FRAME_GOOD, FRAME_CORRUPT, FRAME_BAD_LENGTH, FRAME_NOISE
  } frame_form_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pulse_valid = 1'b0;
  logic pulse_stall;
  pulse_t pulse = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MULTIPLIER;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // register shadows
  logic [7:0] cf_mult = MULTIPLIER_RST;
  logic [LEN_W-1:0] cf_short_min = SHORT_MIN_RST;
  logic [LEN_W-1:0] cf_short_max = SHORT_MAX_RST;
  logic [LEN_W-1:0] cf_long_min = LONG_MIN_RST;
  logic [LEN_W-1:0] cf_long_max = LONG_MAX_RST;
  logic [LEN_W-1:0] cf_header_min = HEADER_MIN_RST;
  logic [LEN_W-1:0] cf_header_max = HEADER_MAX_RST;

  // capture state of the decoder
  logic [IDX_W-1:0] cap_index = '0;
  logic [CODE_W-1:0] cap_code = '0;
  logic cap_failed = 1'b0;
  logic cap_first_long = 1'b0;

  result_t verdict_q[$];
  int error_count = 0;
  int quiet_cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int pulses_sent = 0;
  int verdicts_due = 0;

  pulse_pair_frame_decoder uut (
    .clk(clk),
    .rst(rst),
    .pulse_valid(pulse_valid),
    .pulse_stall(pulse_stall),
    .pulse(pulse),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic pulse_kind_t classify_len(int len);
    if (len < cf_short_min) return PULSE_BAD;
    if (len <= cf_short_max) return PULSE_SHORT;
    if (len < cf_long_min) return PULSE_BAD;
    if (len > cf_long_max) return PULSE_BAD;
    return PULSE_LONG;
  endfunction

  task automatic decode_pulse(pulse_t p);
    int len;
    int n;
    int pair_start;
    pulse_kind_t kind;
    result_t r;
    len = int'(p.pulse_units) * int'(cf_mult);
    n = int'(cap_index) + 1;
    if (n > INDEX_CEILING) n = INDEX_CEILING;
    cap_index = n[IDX_W-1:0];
    if (n == 1) begin
      if (len <= cf_long_min || len >= cf_long_max) cap_failed = 1'b1;
    end else if (n == 2) begin
      if (len <= cf_header_min || len >= cf_header_max) cap_failed = 1'b1;
    end else begin
      pair_start = n[0] ? n : n - 1;
      // pulses after the last pair are not looked at
      if (pair_start + 1 < int'(FRAME_PULSES)) begin
        kind = classify_len(len);
        if (n[0]) begin
          if (kind == PULSE_BAD) cap_failed = 1'b1;
          cap_first_long = (kind == PULSE_LONG);
        end else begin
          if (kind != PULSE_LONG) cap_failed = 1'b1;
          cap_code = (cap_code + CODE_W'(cap_first_long)) << 1;
          cap_first_long = 1'b0;
        end
      end
    end
    if (p.last_pulse) begin
      r.frame_ok = !cap_failed && n == int'(FRAME_PULSES);
      r.code = r.frame_ok ? cap_code : '0;
      verdict_q.push_back(r);
      cap_index = '0;
      cap_code = '0;
      cap_failed = 1'b0;
      cap_first_long = 1'b0;
    end
  endtask

  // result side: random stall, compare each beat with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected result beat: frame_ok %0b code %h", result.frame_ok, result.code);
        error_count++;
      end else begin
        want = verdict_q.pop_front();
        if (result.frame_ok !== want.frame_ok) begin
          $error("frame_ok expected %0b actual %0b", want.frame_ok, result.frame_ok);
          error_count++;
        end
        if (result.code !== want.code) begin
          $error("code expected %h actual %h", want.code, result.code);
          error_count++;
        end
      end
    end
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (pulse_valid && !pulse_stall) || (result_valid && !result_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("pulse_pair_frame_decoder verification failed");
      $finish;
    end
  end

  task automatic send_pulse(logic [7:0] units, logic last);
    pulse_t p;
    p.pulse_units = units;
    p.last_pulse = last;
    while ($urandom_range(99) < idle_pct) begin
      pulse_valid <= 1'b0;
      @(posedge clk);
    end
    pulse_valid <= 1'b1;
    pulse <= p;
    do @(posedge clk); while (pulse_stall);
    decode_pulse(p);
    pulses_sent++;
    if (last) verdicts_due++;
  endtask

  task automatic wait_for_results();
    pulse_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    // a pulse with no result can still be in the pipe
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_MULTIPLIER: cf_mult = val[7:0];
      CFG_SHORT_MIN: cf_short_min = val;
      CFG_SHORT_MAX: cf_short_max = val;
      CFG_LONG_MIN: cf_long_min = val;
      CFG_LONG_MAX: cf_long_max = val;
      CFG_HEADER_MIN: cf_header_min = val;
      CFG_HEADER_MAX: cf_header_max = val;
      default: ;
    endcase
  endtask

  task automatic program_regs(logic [7:0] mult, int smin, int smax, int lmin, int lmax,
                              int hmin, int hmax);
    wait_for_results();
    // upper byte of the multiplier write is ignored by the block
    write_reg(CFG_MULTIPLIER, {8'($urandom_range(255)), mult});
    write_reg(CFG_SHORT_MIN, LEN_W'(smin));
    write_reg(CFG_SHORT_MAX, LEN_W'(smax));
    write_reg(CFG_LONG_MIN, LEN_W'(lmin));
    write_reg(CFG_LONG_MAX, LEN_W'(lmax));
    write_reg(CFG_HEADER_MIN, LEN_W'(hmin));
    write_reg(CFG_HEADER_MAX, LEN_W'(hmax));
    cfg_we <= 1'b0;
  endtask

  // bounds scaled to the multiplier so that well-formed frames are reachable
  task automatic program_scaled(logic [7:0] mult);
    int m;
    m = (mult == 0) ? 1 : int'(mult);
    program_regs(mult, m * 10 + $urandom_range(m - 1), m * 20, m * 30 - $urandom_range(m - 1),
                 m * 45, m * 70, m * 90);
  endtask

  // duration window a pulse at this position should fall in
  function automatic void pulse_window(int pos, output int lo, output int hi);
    lo = 0;
    hi = 65535;
    if (pos == 1) begin
      lo = int'(cf_long_min) + 1;
      hi = int'(cf_long_max) - 1;
    end else if (pos == 2) begin
      lo = int'(cf_header_min) + 1;
      hi = int'(cf_header_max) - 1;
    end else if (pos + 1 < int'(FRAME_PULSES) || (pos % 2 == 0 && pos < int'(FRAME_PULSES))) begin
      if (pos % 2 == 1 && $urandom_range(1) == 0) begin
        lo = int'(cf_short_min);
        hi = int'(cf_short_max);
      end else begin
        lo = int'(cf_long_min);
        hi = int'(cf_long_max);
      end
    end
  endfunction

  function automatic logic [7:0] units_in(int lo, int hi);
    int m;
    int umin;
    int umax;
    m = int'(cf_mult);
    if (m == 0 || lo > hi) return 8'($urandom_range(255));
    umin = (lo < 0) ? 0 : (lo + m - 1) / m;
    umax = hi / m;
    if (umax > 255) umax = 255;
    if (umin > umax) return 8'($urandom_range(255));
    case ($urandom_range(3))
      0: return 8'(umin);
      1: return 8'(umax);
      default: return 8'($urandom_range(umax, umin));
    endcase
  endfunction

  // just outside the window, so the inclusive and exclusive edges get hit
  function automatic logic [7:0] units_beside(int lo, int hi);
    int m;
    int u;
    m = int'(cf_mult);
    if (m == 0 || $urandom_range(1) == 0) return 8'($urandom_range(255));
    u = $urandom_range(1) ? (lo + m - 1) / m - 1 : hi / m + 1;
    if (u < 0 || u > 255) return 8'($urandom_range(255));
    return 8'(u);
  endfunction

  function automatic logic [7:0] shaped_units(int pos);
    int lo;
    int hi;
    pulse_window(pos, lo, hi);
    return units_in(lo, hi);
  endfunction

  task automatic send_frame(frame_form_t form);
    int n;
    int bad_pos;
    int lo;
    int hi;
    logic [7:0] u;
    n = int'(FRAME_PULSES);
    bad_pos = 0;
    case (form)
      FRAME_CORRUPT: bad_pos = $urandom_range(1, n);
      FRAME_BAD_LENGTH: begin
        // now and then run past the index ceiling
        n = ($urandom_range(9) == 0) ? $urandom_range(128, 140) : $urandom_range(1, 100);
        if (n == int'(FRAME_PULSES)) n++;
      end
      FRAME_NOISE: n = $urandom_range(1, 8);
      default: ;
    endcase
    for (int pos = 1; pos <= n; pos++) begin
      if (form == FRAME_NOISE) begin
        u = 8'($urandom_range(255));
      end else if (pos == bad_pos) begin
        pulse_window(pos, lo, hi);
        u = units_beside(lo, hi);
      end else begin
        u = shaped_units(pos);
      end
      send_pulse(u, pos == n);
    end
  endtask

  task automatic run_traffic(int n_pulses, int n_verdicts, bit shuffle_idle, bit hold_midway);
    int start_pulses;
    int start_verdicts;
    int pick;
    bit held;
    start_pulses = pulses_sent;
    start_verdicts = verdicts_due;
    held = 1'b0;
    while (pulses_sent - start_pulses < n_pulses || verdicts_due - start_verdicts < n_verdicts)
    begin
      if (shuffle_idle) begin
        case ($urandom_range(3))
          0: begin idle_pct = 0; stall_pct = 0; end
          1: begin idle_pct = 75; stall_pct = 0; end
          2: begin idle_pct = 0; stall_pct = 75; end
          default: begin idle_pct = 11; stall_pct = 11; end
        endcase
      end
      if (hold_midway && !held && pulses_sent - start_pulses > n_pulses / 2) begin
        wait_for_results();
        held = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 55) send_frame(FRAME_GOOD);
      else if (pick < 70) send_frame(FRAME_CORRUPT);
      else if (pick < 85) send_frame(FRAME_BAD_LENGTH);
      else send_frame(FRAME_NOISE);
    end
  endtask

  // single pulses flagged last: extremes and alternating bit patterns of the pulse field
  task automatic test_lone_pulses();
    send_pulse(8'h00, 1'b1);
    send_pulse(8'hFF, 1'b1);
    send_pulse(8'hAA, 1'b1);
    send_pulse(8'h55, 1'b1);
  endtask

  // captures that end early, including right after the header
  task automatic test_short_captures();
    send_pulse(shaped_units(1), 1'b0);
    send_pulse(shaped_units(2), 1'b1);
    for (int pos = 1; pos <= 3; pos++) send_pulse(shaped_units(pos), pos == 3);
    for (int pos = 1; pos <= 10; pos++) send_pulse(shaped_units(pos), pos == 10);
  endtask

  task automatic test_reset_register_frames();
    idle_pct = 0;
    stall_pct = 0;
    run_traffic(300, 10, 1'b0, 1'b0);
  endtask

  task automatic test_unit_multiplier_edges();
    program_regs(8'd1, 40, 60, 100, 150, 200, 250);
    idle_pct = 75;
    stall_pct = 0;
    run_traffic(280, 10, 1'b0, 1'b0);
  endtask

  task automatic test_extreme_bounds();
    // zero duration is short, anything else is long
    program_regs(8'd255, 0, 0, 0, 65535, 0, 65535);
    idle_pct = 0;
    stall_pct = 75;
    run_traffic(200, 8, 1'b0, 1'b0);
    program_regs(8'd255, 65535, 65535, 65535, 65535, 65535, 65535);
    run_traffic(60, 3, 1'b0, 1'b0);
  endtask

  task automatic test_zero_multiplier();
    program_scaled(8'($urandom_range(1, 255)));
    @(posedge clk);
    write_reg(CFG_MULTIPLIER, {8'($urandom_range(255)), 8'd0});
    cfg_we <= 1'b0;
    idle_pct = 11;
    stall_pct = 11;
    run_traffic(150, 8, 1'b0, 1'b0);
  endtask

  task automatic test_random_registers();
    program_scaled(8'($urandom_range(1, 255)));
    run_traffic(200, 8, 1'b1, 1'b1);
    program_regs(MULTIPLIER_RST, SHORT_MIN_RST, SHORT_MAX_RST, LONG_MIN_RST, LONG_MAX_RST,
                 HEADER_MIN_RST, HEADER_MAX_RST);
    run_traffic(150, 6, 1'b1, 1'b0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_lone_pulses();
    test_short_captures();
    test_reset_register_frames();
    test_unit_multiplier_edges();
    test_extreme_bounds();
    test_zero_multiplier();
    test_random_registers();
    wait_for_results();
    if (error_count == 0)
      $display("pulse_pair_frame_decoder verification clean");
    else
      $display("pulse_pair_frame_decoder verification failed");
    $finish;
  end

endmodule
